// ===== design/crd_pkg.sv =====
// Shared constants, result codes and types of the configuration record decoder.
package crd_pkg;

    localparam int RECORD_BYTES = 32;
    localparam int CRC_SPAN     = 28;
    localparam int COUNT_W      = 6;
    localparam int IDX_W        = $clog2(RECORD_BYTES);
    localparam int CFG_IDX_W    = 2;

    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

    // result reason codes
    localparam logic [3:0] RSN_OK      = 4'd0;
    localparam logic [3:0] RSN_EMPTY   = 4'd1;
    localparam logic [3:0] RSN_LENGTH  = 4'd2;
    localparam logic [3:0] RSN_MAGIC   = 4'd3;
    localparam logic [3:0] RSN_SCHEMA  = 4'd4;
    localparam logic [3:0] RSN_PAYLOAD = 4'd5;
    localparam logic [3:0] RSN_FLAGS   = 4'd6;
    localparam logic [3:0] RSN_CRC     = 4'd7;
    localparam logic [3:0] RSN_BOUNDS  = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEMA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD = 2'd2;

    localparam logic [31:0] MAGIC_RST   = 32'd0;
    localparam logic [15:0] SCHEMA_RST  = 16'd1;
    localparam logic [15:0] PAYLOAD_RST = 16'd16;

    // field bounds
    localparam logic [15:0] TARGET_LO  = 16'd800;
    localparam logic [15:0] TARGET_HI  = 16'd1400;
    localparam logic [15:0] MIN_HI     = 16'd800;
    localparam logic [15:0] MAX_LO     = 16'd500;
    localparam logic [15:0] MAX_HI     = 16'd1000;
    localparam logic [15:0] ALARM_LO   = 16'd1200;
    localparam logic [15:0] ALARM_HI   = 16'd2500;
    localparam logic [15:0] DELAY_LO   = 16'd10;
    localparam logic [15:0] DELAY_HI   = 16'd600;
    localparam logic [15:0] TEST_LO    = 16'd30;
    localparam logic [15:0] TEST_HI    = 16'd600;
    localparam logic [15:0] HISTORY_LO = 16'd10;
    localparam logic [15:0] HISTORY_HI = 16'd300;

    typedef logic [RECORD_BYTES-1:0][7:0] t_record;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] schema_version;
        logic [15:0] payload_size;
    } t_cfg_regs;

    typedef struct packed {
        logic [3:0]  reason;
        logic [31:0] generation;
        logic [15:0] setpoint_ppm;
        logic [15:0] min_output_tenths;
        logic [15:0] max_output_tenths;
        logic [15:0] alarm_level_ppm;
        logic [15:0] alarm_wait_sec;
        logic [15:0] selftest_sec;
        logic [15:0] log_interval_sec;
    } t_result;

endpackage

// ===== design/crd_if.sv =====
// Handshake channels of the decoder: record bytes in, decoded results out, register writes.
interface crd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;
    logic       no_record;

    modport source (output valid, byte_value, last_byte, no_record, input ready);
    modport sink   (input valid, byte_value, last_byte, no_record, output ready);
endinterface

interface crd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  reason;
    logic [31:0] generation;
    logic [15:0] setpoint_ppm;
    logic [15:0] min_output_tenths;
    logic [15:0] max_output_tenths;
    logic [15:0] alarm_level_ppm;
    logic [15:0] alarm_wait_sec;
    logic [15:0] selftest_sec;
    logic [15:0] log_interval_sec;

    modport source (output valid, reason, generation, setpoint_ppm, min_output_tenths,
                    max_output_tenths, alarm_level_ppm, alarm_wait_sec, selftest_sec,
                    log_interval_sec, input ready);
    modport sink   (input valid, reason, generation, setpoint_ppm, min_output_tenths,
                    max_output_tenths, alarm_level_ppm, alarm_wait_sec, selftest_sec,
                    log_interval_sec, output ready);
endinterface

interface crd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/crd_check.sv =====
// Record checker: length, header, flags, CRC and field bound checks, and field extraction.
module crd_check (
    input  crd_pkg::t_record   i_rec,
    input  logic               i_len_ok,
    input  logic [31:0]        i_crc,
    input  crd_pkg::t_cfg_regs i_cfg,
    output crd_pkg::t_result   o_res
);
    import crd_pkg::*;

    logic [31:0] w_magic;
    logic [15:0] w_schema;
    logic [15:0] w_payload;
    logic [15:0] w_flags;
    logic [31:0] w_crc_rx;
    logic [31:0] w_gen;
    logic [15:0] w_tgt, w_mn, w_mx, w_alarm, w_delay, w_test, w_hist;
    logic        w_bounds_ok;

    assign w_magic   = {i_rec[3], i_rec[2], i_rec[1], i_rec[0]};
    assign w_schema  = {i_rec[5], i_rec[4]};
    assign w_payload = {i_rec[7], i_rec[6]};
    assign w_gen     = {i_rec[11], i_rec[10], i_rec[9], i_rec[8]};
    assign w_tgt     = {i_rec[13], i_rec[12]};
    assign w_mn      = {i_rec[15], i_rec[14]};
    assign w_mx      = {i_rec[17], i_rec[16]};
    assign w_alarm   = {i_rec[19], i_rec[18]};
    assign w_delay   = {i_rec[21], i_rec[20]};
    assign w_test    = {i_rec[23], i_rec[22]};
    assign w_hist    = {i_rec[25], i_rec[24]};
    assign w_flags   = {i_rec[27], i_rec[26]};
    assign w_crc_rx  = {i_rec[31], i_rec[30], i_rec[29], i_rec[28]};

    // minimum tenths has no lower bound beyond zero
    assign w_bounds_ok = (w_tgt >= TARGET_LO) && (w_tgt <= TARGET_HI)
                      && (w_mn <= MIN_HI)
                      && (w_mx >= MAX_LO) && (w_mx <= MAX_HI)
                      && (w_mn <= w_mx)
                      && (w_alarm >= ALARM_LO) && (w_alarm <= ALARM_HI)
                      && (w_alarm > w_tgt)
                      && (w_delay >= DELAY_LO) && (w_delay <= DELAY_HI)
                      && (w_test >= TEST_LO) && (w_test <= TEST_HI)
                      && (w_hist >= HISTORY_LO) && (w_hist <= HISTORY_HI);

    always_comb begin
        o_res = '0;
        if (!i_len_ok) begin
            o_res.reason = RSN_LENGTH;
        end else if (w_magic != i_cfg.magic_word) begin
            o_res.reason = RSN_MAGIC;
        end else if (w_schema != i_cfg.schema_version) begin
            o_res.reason = RSN_SCHEMA;
        end else if (w_payload != i_cfg.payload_size) begin
            o_res.reason = RSN_PAYLOAD;
        end else if (w_flags != 16'd0) begin
            o_res.reason = RSN_FLAGS;
        end else if (w_crc_rx != ~i_crc) begin
            o_res.reason = RSN_CRC;
        end else if (!w_bounds_ok) begin
            o_res.reason = RSN_BOUNDS;
        end else begin
            o_res.reason            = RSN_OK;
            o_res.generation        = w_gen;
            o_res.setpoint_ppm      = w_tgt;
            o_res.min_output_tenths = w_mn;
            o_res.max_output_tenths = w_mx;
            o_res.alarm_level_ppm   = w_alarm;
            o_res.alarm_wait_sec    = w_delay;
            o_res.selftest_sec      = w_test;
            o_res.log_interval_sec  = w_hist;
        end
    end

endmodule

// ===== design/config_record_decoder.sv =====
// Top level of the configuration record decoder.
// Takes a 32-byte settings record one byte per item and gives one result per record, on the
// last byte, or at once for an item marked no_record. One byte is accepted every cycle while
// the input does not stall, as the CRC-32 is unrolled over a whole byte. A record's last byte
// passes through the input register and then the result register, with all checks done
// between them. The input stalls only while a result waits at the output and the next
// result-making item already sits in the input register.
// The next record may start right behind the last byte.
// Registers (magic, schema, payload size) are written through the config channel, which is
// always ready; an index of 3 is ignored.
module config_record_decoder (
    input  logic i_clk,
    input  logic i_rst_n,
    crd_in_if.sink    i_rec,
    crd_out_if.source o_res,
    crd_cfg_if.sink   i_cfg
);
    import crd_pkg::*;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
        end
        return v;
    endfunction

    t_cfg_regs            r_cfg;
    logic                 r_s1_valid;
    logic [7:0]           r_s1_byte;
    logic                 r_s1_last;
    logic                 r_s1_norec;
    logic [COUNT_W-1:0]   r_count;
    logic [31:0]          r_crc;
    logic [7:0]           r_store [RECORD_BYTES];
    logic                 r_out_valid;
    t_result              r_out;
    t_result              n_out;

    logic                 w_s1_result;
    logic                 w_out_free;
    logic                 w_s1_go;
    t_record              w_rec;
    t_result              w_chk;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word     <= MAGIC_RST;
            r_cfg.schema_version <= SCHEMA_RST;
            r_cfg.payload_size   <= PAYLOAD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAGIC:   r_cfg.magic_word     <= i_cfg.data;
                CFG_SCHEMA:  r_cfg.schema_version <= i_cfg.data[15:0];
                CFG_PAYLOAD: r_cfg.payload_size   <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    assign w_s1_result = r_s1_valid && (r_s1_last || r_s1_norec);
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_s1_go     = r_s1_valid && (!w_s1_result || w_out_free);
    assign i_rec.ready = !r_s1_valid || w_s1_go;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_rec.ready) begin
            r_s1_valid <= i_rec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rec.ready && i_rec.valid) begin
            r_s1_byte  <= i_rec.byte_value;
            r_s1_last  <= i_rec.last_byte;
            r_s1_norec <= i_rec.no_record;
        end
    end

    // running record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else if (w_s1_go) begin
            if (r_s1_norec || r_s1_last) begin
                r_count <= '0;
                r_crc   <= CRC_INIT;
            end else begin
                if (r_count < COUNT_W'(CRC_SPAN)) begin
                    r_crc <= crc_byte(r_crc, r_s1_byte);
                end
                if (r_count != '1) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && !r_s1_norec && (r_count < COUNT_W'(RECORD_BYTES))) begin
            r_store[r_count[IDX_W-1:0]] <= r_s1_byte;
        end
    end

    // the final byte is checked straight from the input register
    always_comb begin
        for (int i = 0; i < RECORD_BYTES - 1; i++) begin
            w_rec[i] = r_store[i];
        end
        w_rec[RECORD_BYTES-1] = r_s1_byte;
    end

    crd_check u_check (
        .i_rec    (w_rec),
        .i_len_ok (r_count == COUNT_W'(RECORD_BYTES - 1)),
        .i_crc    (r_crc),
        .i_cfg    (r_cfg),
        .o_res    (w_chk)
    );

    always_comb begin
        n_out = w_chk;
        if (r_s1_norec) begin
            n_out        = '0;
            n_out.reason = RSN_EMPTY;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && w_s1_result) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && w_s1_result) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.reason            = r_out.reason;
    assign o_res.generation        = r_out.generation;
    assign o_res.setpoint_ppm      = r_out.setpoint_ppm;
    assign o_res.min_output_tenths = r_out.min_output_tenths;
    assign o_res.max_output_tenths = r_out.max_output_tenths;
    assign o_res.alarm_level_ppm   = r_out.alarm_level_ppm;
    assign o_res.alarm_wait_sec    = r_out.alarm_wait_sec;
    assign o_res.selftest_sec      = r_out.selftest_sec;
    assign o_res.log_interval_sec  = r_out.log_interval_sec;

    a_restart_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_go && w_s1_result) |=> (r_count == '0 && r_crc == CRC_INIT))
        else $error("record state not restarted after a result");

    a_fields_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.reason != RSN_OK) |->
        (r_out.generation == '0 && r_out.setpoint_ppm == '0 && r_out.log_interval_sec == '0))
        else $error("nonzero fields on a failed result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_result && !w_out_free) |=> (r_s1_valid && $stable(r_s1_byte)))
        else $error("pending item lost while result stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rec.ready |-> (r_s1_valid && r_out_valid && !o_res.ready))
        else $error("input stalled without a stalled result");

endmodule

// ===== tb/sv/crd_result_checker.sv =====
// CRC helper shared by the testbench and the result checker of the record decoder.
package crd_crc_pkg;

    import crd_pkg::*;

    // reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

module crd_result_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crd_in_if         i_rec,
    crd_out_if        i_res,
    crd_cfg_if        i_cfg,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import crd_pkg::*;
    import crd_crc_pkg::*;

    logic [COUNT_W-1:0] taken;
    logic [31:0]        crc_acc;
    logic [7:0]         rec_mem [RECORD_BYTES];
    t_cfg_regs          regs;
    t_result            awaited_results [$];
    int                 errs = 0;

    function automatic logic [15:0] le16(int at);
        return {rec_mem[at + 1], rec_mem[at]};
    endfunction

    function automatic logic [31:0] le32(int at);
        return {le16(at + 2), le16(at)};
    endfunction

    function automatic logic [3:0] judge_record();
        logic [15:0] tgt, mn, mx, alarm, delay, test_s, hist;
        tgt   = le16(12);
        mn    = le16(14);
        mx    = le16(16);
        alarm = le16(18);
        delay = le16(20);
        test_s = le16(22);
        hist  = le16(24);
        if (taken != RECORD_BYTES) return RSN_LENGTH;
        if (le32(0) != regs.magic_word) return RSN_MAGIC;
        if (le16(4) != regs.schema_version) return RSN_SCHEMA;
        if (le16(6) != regs.payload_size) return RSN_PAYLOAD;
        if (le16(26) != 16'd0) return RSN_FLAGS;
        if (le32(28) != ~crc_acc) return RSN_CRC;
        if (tgt < TARGET_LO || tgt > TARGET_HI) return RSN_BOUNDS;
        if (mn > MIN_HI) return RSN_BOUNDS;
        if (mx < MAX_LO || mx > MAX_HI) return RSN_BOUNDS;
        if (mn > mx) return RSN_BOUNDS;
        if (alarm < ALARM_LO || alarm > ALARM_HI) return RSN_BOUNDS;
        if (alarm <= tgt) return RSN_BOUNDS;
        if (delay < DELAY_LO || delay > DELAY_HI) return RSN_BOUNDS;
        if (test_s < TEST_LO || test_s > TEST_HI) return RSN_BOUNDS;
        if (hist < HISTORY_LO || hist > HISTORY_HI) return RSN_BOUNDS;
        return RSN_OK;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic last, input logic empty);
        t_result r;
        r = '0;
        if (empty) begin
            r.reason = RSN_EMPTY;
        end else begin
            if (taken < RECORD_BYTES) rec_mem[taken] = b;
            if (taken < CRC_SPAN) crc_acc = crc32_step(crc_acc, b);
            if (taken != '1) taken++;
            if (!last) return;
            r.reason = judge_record();
            if (r.reason == RSN_OK) begin
                r.generation        = le32(8);
                r.setpoint_ppm      = le16(12);
                r.min_output_tenths = le16(14);
                r.max_output_tenths = le16(16);
                r.alarm_level_ppm   = le16(18);
                r.alarm_wait_sec    = le16(20);
                r.selftest_sec      = le16(22);
                r.log_interval_sec  = le16(24);
            end
        end
        awaited_results.push_back(r);
        taken   = '0;
        crc_acc = CRC_INIT;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errs++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            taken   = '0;
            crc_acc = CRC_INIT;
            regs    = '{MAGIC_RST, SCHEMA_RST, PAYLOAD_RST};
            awaited_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_MAGIC:   regs.magic_word = i_cfg.data;
                    CFG_SCHEMA:  regs.schema_version = i_cfg.data[15:0];
                    CFG_PAYLOAD: regs.payload_size = i_cfg.data[15:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no record pending: reason %0d", i_res.reason);
                    errs++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("reason", want.reason, i_res.reason);
                    check_field("generation", want.generation, i_res.generation);
                    check_field("setpoint_ppm", want.setpoint_ppm, i_res.setpoint_ppm);
                    check_field("min_output_tenths", want.min_output_tenths,
                                i_res.min_output_tenths);
                    check_field("max_output_tenths", want.max_output_tenths,
                                i_res.max_output_tenths);
                    check_field("alarm_level_ppm", want.alarm_level_ppm, i_res.alarm_level_ppm);
                    check_field("alarm_wait_sec", want.alarm_wait_sec, i_res.alarm_wait_sec);
                    check_field("selftest_sec", want.selftest_sec, i_res.selftest_sec);
                    check_field("log_interval_sec", want.log_interval_sec,
                                i_res.log_interval_sec);
                end
            end
            if (i_rec.valid && i_rec.ready) begin
                take_byte(i_rec.byte_value, i_rec.last_byte, i_rec.no_record);
            end
        end
        o_pending <= awaited_results.size();
        o_errors  <= errs;
    end

endmodule

// ===== tb/sv/tb_config_record_decoder.sv =====
// Top of the record decoder testbench: clock, reset, record stimulus and verdict.
module tb_config_record_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import crd_pkg::*;
    import crd_crc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 120;
    localparam int PHASE_RESULTS = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef logic [7:0] t_byte_q [$];
    // target, min, max, alarm, delay, test, history
    typedef logic [6:0][15:0] t_fields;
    typedef enum int {
        FLAW_NONE, FLAW_MAGIC, FLAW_SCHEMA, FLAW_PAYLOAD, FLAW_FLAGS, FLAW_CRC, FLAW_BOUNDS
    } t_flaw;

    localparam int F_TARGET = 0;
    localparam int F_MIN    = 1;
    localparam int F_MAX    = 2;
    localparam int F_ALARM  = 3;
    localparam t_fields FIELD_LO =
        {HISTORY_LO, TEST_LO, DELAY_LO, ALARM_LO, MAX_LO, 16'd0, TARGET_LO};
    localparam t_fields FIELD_HI =
        {HISTORY_HI, TEST_HI, DELAY_HI, ALARM_HI, MAX_HI, MIN_HI, TARGET_HI};

    logic i_clk;
    logic i_rst_n;

    crd_in_if  rec_if ();
    crd_out_if res_if ();
    crd_cfg_if cfg_if ();

    int          err_cnt;
    int          pending_cnt;
    int          cycle_cnt = 0;
    int          sent_items = 0;
    int          sent_results = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_go = 1'b0;
    logic        long_hold;
    logic [31:0] cur_magic = MAGIC_RST;
    logic [15:0] cur_schema = SCHEMA_RST;
    logic [15:0] cur_payload = PAYLOAD_RST;

    config_record_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    crd_result_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rec     (rec_if),
        .i_res     (res_if),
        .i_cfg     (cfg_if),
        .o_errors  (err_cnt),
        .o_pending (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL config_record_decoder");
            $finish;
        end
    end

    // long receiver hold-off so the decoder backs up into its input
    initial begin
        long_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= !long_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [15:0] pick_within(logic [15:0] lo, logic [15:0] hi);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return 16'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic logic [15:0] pick_outside(logic [15:0] lo, logic [15:0] hi);
        if (lo != 16'd0 && $urandom_range(1)) begin
            return $urandom_range(1) ? lo - 16'd1 : 16'($urandom_range(lo - 1));
        end
        return $urandom_range(1) ? hi + 16'd1 : 16'($urandom_range(16'hffff, hi + 1));
    endfunction

    function automatic t_fields good_fields();
        t_fields f;
        for (int k = 0; k < 7; k++) f[k] = pick_within(FIELD_LO[k], FIELD_HI[k]);
        if (f[F_MIN] > f[F_MAX]) f[F_MAX] = f[F_MIN];
        if (f[F_ALARM] <= f[F_TARGET]) f[F_ALARM] = 16'($urandom_range(ALARM_HI, f[F_TARGET] + 1));
        return f;
    endfunction

    function automatic t_fields break_bounds(t_fields f);
        int k;
        k = $urandom_range(8);
        if (k < 7) begin
            f[k] = pick_outside(FIELD_LO[k], FIELD_HI[k]);
        end else if (k == 7) begin
            // each inside its own range, but min above max
            f[F_MAX] = 16'($urandom_range(MIN_HI - 1, MAX_LO));
            f[F_MIN] = 16'($urandom_range(MIN_HI, f[F_MAX] + 1));
        end else begin
            // alarm not above target
            f[F_TARGET] = 16'($urandom_range(TARGET_HI, ALARM_LO));
            f[F_ALARM]  = 16'($urandom_range(f[F_TARGET], ALARM_LO));
        end
        return f;
    endfunction

    function automatic t_byte_q random_bytes(int n);
        t_byte_q q;
        repeat (n) q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic void push_le(ref t_byte_q q, input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void flip_bit(ref t_byte_q q, input int lo, input int hi);
        int at;
        at = $urandom_range(hi, lo);
        q[at] = q[at] ^ (8'h01 << $urandom_range(7));
    endfunction

    // 32-byte image for the current settings, with at most one defect
    task automatic make_record(input t_flaw flaw, input t_fields f, input logic [31:0] gen,
                               output t_byte_q img);
        logic [31:0] crc;
        img = {};
        if (flaw == FLAW_BOUNDS) f = break_bounds(f);
        push_le(img, cur_magic, 4);
        push_le(img, 32'(cur_schema), 2);
        push_le(img, 32'(cur_payload), 2);
        push_le(img, gen, 4);
        for (int k = 0; k < 7; k++) push_le(img, 32'(f[k]), 2);
        push_le(img, 32'd0, 2);
        case (flaw)
            FLAW_MAGIC:   flip_bit(img, 0, 3);
            FLAW_SCHEMA:  flip_bit(img, 4, 5);
            FLAW_PAYLOAD: flip_bit(img, 6, 7);
            FLAW_FLAGS:   flip_bit(img, 26, 27);
            default: ;
        endcase
        crc = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) crc = crc32_step(crc, img[i]);
        push_le(img, ~crc, 4);
        if (flaw == FLAW_CRC) flip_bit(img, 28, 31);
    endtask

    task automatic put_item(input logic [7:0] b, input logic last, input logic empty);
        while ($urandom_range(99) < idle_pct) begin
            rec_if.valid      <= 1'b0;
            rec_if.byte_value <= 8'($urandom);
            @(posedge i_clk);
        end
        rec_if.valid      <= 1'b1;
        rec_if.byte_value <= b;
        rec_if.last_byte  <= last;
        rec_if.no_record  <= empty;
        do @(posedge i_clk); while (rec_if.ready !== 1'b1);
        sent_items++;
        if (last || empty) sent_results++;
    endtask

    task automatic send_bytes(input t_byte_q img, input logic closed);
        foreach (img[i]) put_item(img[i], closed && (i == img.size() - 1), 1'b0);
    endtask

    // stop offering, wait for every result, then wait on for bytes still in flight
    task automatic drain();
        rec_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_MAGIC:   cur_magic = v;
            CFG_SCHEMA:  cur_schema = v[15:0];
            CFG_PAYLOAD: cur_payload = v[15:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] magic, input logic [15:0] schema,
                                 input logic [15:0] payload);
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_SCHEMA, {16'($urandom), schema});
        write_reg(CFG_PAYLOAD, {16'($urandom), payload});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_directed();
        t_byte_q img;
        put_item(8'hff, 1'b1, 1'b1);
        put_item(8'h00, 1'b1, 1'b0);
        make_record(FLAW_NONE, FIELD_LO, 32'd0, img);
        send_bytes(img, 1'b1);
        make_record(FLAW_NONE, FIELD_HI, 32'hffff_ffff, img);
        send_bytes(img, 1'b1);
        // partial record thrown away by an empty slot
        make_record(FLAW_NONE, good_fields(), $urandom, img);
        send_bytes(img[0:9], 1'b0);
        put_item(8'h5a, 1'b0, 1'b1);
        // overlong record, count saturates
        send_bytes(random_bytes(64), 1'b1);
        drain();
        write_reg(CFG_SPARE, $urandom);
        cfg_if.valid <= 1'b0;
        make_record(FLAW_NONE, good_fields(), $urandom, img);
        send_bytes(img, 1'b1);
    endtask

    task automatic run_random(input logic pause_midway);
        t_byte_q img;
        int      first_items;
        int      first_results;
        int      pick;
        int      n;
        logic    paused;
        first_items   = sent_items;
        first_results = sent_results;
        paused        = 1'b0;
        while (sent_items - first_items < PHASE_ITEMS ||
               sent_results - first_results < PHASE_RESULTS) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                make_record(FLAW_NONE, good_fields(), $urandom, img);
                send_bytes(img, 1'b1);
            end else if (pick < 70) begin
                make_record(t_flaw'($urandom_range(FLAW_BOUNDS, FLAW_MAGIC)), good_fields(),
                            $urandom, img);
                send_bytes(img, 1'b1);
            end else if (pick < 78) begin
                send_bytes(random_bytes($urandom_range(RECORD_BYTES - 1, 1)), 1'b1);
            end else if (pick < 84) begin
                send_bytes(random_bytes($urandom_range(70, RECORD_BYTES + 1)), 1'b1);
            end else if (pick < 90) begin
                put_item(8'($urandom), 1'($urandom), 1'b1);
            end else if (pick < 95) begin
                make_record(FLAW_NONE, good_fields(), $urandom, img);
                n = $urandom_range(RECORD_BYTES - 1, 1);
                send_bytes(img[0:n-1], 1'b0);
                put_item(8'($urandom), 1'($urandom), 1'b1);
            end else begin
                send_bytes(random_bytes(RECORD_BYTES), 1'b1);
            end
            if (pause_midway && !paused &&
                sent_results - first_results >= PHASE_RESULTS / 2) begin
                drain();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        rec_if.valid      = 1'b0;
        rec_if.byte_value = 8'd0;
        rec_if.last_byte  = 1'b0;
        rec_if.no_record  = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_MAGIC;
        cfg_if.data       = 32'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first records run on the reset settings
        run_directed();

        for (int p = 0; p < 4; p++) begin
            drain();
            case (p)
                0: load_settings(32'hffff_ffff, 16'hffff, 16'hffff);
                1: load_settings(32'd0, 16'd0, 16'd0);
                default: load_settings($urandom, 16'($urandom), 16'($urandom));
            endcase
            idle_pct  = (p == 1) ? 54 : (p == 3) ? 15 : 0;
            stall_pct = (p == 2) ? 54 : (p == 3) ? 15 : 0;
            if (p == 0) hold_go = 1'b1;
            run_random(p == 2);
        end
        drain();

        if (err_cnt == 0) begin
            $display("PASS config_record_decoder");
        end else begin
            $display("FAIL config_record_decoder");
        end
        $finish;
    end

endmodule

// ===== config_record_decoder.f =====
design/crd_pkg.sv
design/crd_if.sv
design/crd_check.sv
design/config_record_decoder.sv
tb/sv/crd_result_checker.sv
tb/sv/tb_config_record_decoder.sv
